/* hdl/ffr_pkg.sv */
// Shared types, constants and helpers for the fixed-length frame receiver.
// No dependencies; imported by every module in hdl/.
package ffr_pkg;

    // FIFO sizing
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Frame layout: header, then five bytes; check byte is the last
    localparam int FRAME_TAIL = 5;
    localparam int IDX_W      = 3;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_HEADER    = cfg_idx_t'(0);
    localparam cfg_idx_t REG_ENABLE_ID = cfg_idx_t'(1);

    localparam logic [7:0] HEADER_RESET    = 8'hAA;
    localparam logic [7:0] ENABLE_ID_RESET = 8'h29;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Five frame bytes after the header, byte one in the low bits
    typedef struct packed {
        logic [7:0] check_byte;
        logic [7:0] data_second;
        logic [7:0] data_first;
        logic [7:0] msg_id;
        logic [7:0] second_byte;
    } frame_t;

    // Completion event from the deframer
    typedef struct packed {
        logic done;      // this byte ended a frame
        logic sum_ok;    // zero-sum check passed
        logic is_enable; // message id matches the enable id
    } frm_evt_t;

    // Queue control from the top level to the FIFO
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    // FIFO fill level clipped to the four-bit count field
    function automatic logic [3:0] sat_count(input cnt_t c);
        logic [3:0] r;
        if (int'(c) > 15)
            r = 4'd15;
        else
            r = 4'(c);
        return r;
    endfunction

    // Pointer increment with wrap at the FIFO depth
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (int'(p) == FIFO_DEPTH - 1)
            r = '0;
        else
            r = ptr_t'(p + ptr_t'(1));
        return r;
    endfunction

endpackage

/* hdl/ffr_deframer.sv */
// Header hunt, five-byte assembly and zero-sum check.
// Depends on ffr_pkg.
module ffr_deframer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      header_value,
    input  logic [7:0]      enable_msg_id,
    output ffr_pkg::frm_evt_t evt,
    output ffr_pkg::frame_t   frame
);
    import ffr_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       buf_reg [FRAME_TAIL-1];
    logic             last_byte;
    logic [7:0]       sum;

    // Current byte is the check byte when the fifth slot is due
    assign last_byte = in_frame_reg && (idx_reg == IDX_W'(FRAME_TAIL));
    assign sum       = buf_reg[1] + buf_reg[2] + buf_reg[3] + rx_byte;

    assign frame.second_byte = buf_reg[0];
    assign frame.msg_id      = buf_reg[1];
    assign frame.data_first  = buf_reg[2];
    assign frame.data_second = buf_reg[3];
    assign frame.check_byte  = rx_byte;

    assign evt.done      = take && last_byte;
    assign evt.sum_ok    = (sum == 8'h00);
    assign evt.is_enable = (buf_reg[1] == enable_msg_id);

    // Hunt / collect sequencing
    always_comb
    begin
        in_frame_next = in_frame_reg;
        idx_next      = idx_reg;
        if (take)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == header_value)
                begin
                    in_frame_next = 1'b1;
                    idx_next      = IDX_W'(1);
                end
            end
            else if (last_byte)
            begin
                in_frame_next = 1'b0;
                idx_next      = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            idx_reg      <= idx_next;
        end
    end

    // Assembly buffer: bytes one to four
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_TAIL - 1; i++)
        begin
            if (take && in_frame_reg && (idx_reg == IDX_W'(i + 1)))
                buf_reg[i] <= rx_byte;
        end
    end

endmodule

/* hdl/ffr_frame_fifo.sv */
// Frame queue: memory, pointers, fill count and registered read data.
// Depends on ffr_pkg.
module ffr_frame_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  ffr_pkg::fifo_ctl_t ctl,
    input  ffr_pkg::frame_t    wr_data,
    output ffr_pkg::frame_t    rd_data,
    output ffr_pkg::cnt_t      count,
    output logic               full,
    output logic               empty
);
    import ffr_pkg::*;

    frame_t mem [FIFO_DEPTH];
    frame_t rd_data_reg;
    ptr_t   wr_ptr_reg, rd_ptr_reg;
    cnt_t   count_reg, count_next;

    assign full    = (int'(count_reg) == FIFO_DEPTH);
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = rd_data_reg;

    // Caller only pushes when not full and pops when not empty
    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
            count_next = count_reg + cnt_t'(1);
        else if (ctl.pop)
            count_next = count_reg - cnt_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctl.push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (ctl.pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
        end
    end

    // Storage with registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[wr_ptr_reg] <= wr_data;
        if (ctl.pop)
            rd_data_reg <= mem[rd_ptr_reg];
    end

endmodule

/* hdl/fixed_frame_receiver_fifo_top.sv */
// Fixed-length frame receiver: one item a cycle while the result side keeps ready high; an
// item waits in the input register and is processed as it moves into the result register,
// which holds its result until taken; back-to-back items follow with no gaps. A result held
// by a low out_ready keeps the input register full and stalls the input until it is taken.
// Each received byte or pop is checked against the frame state in that single step, limited
// only by the four-byte checksum adder and the FIFO's memory read and write. Queued frames come
// back through a registered read, so popped bytes are valid with the result. Configuration
// writes are always accepted and should be made with no items in flight.
//
// Depends on ffr_pkg, ffr_deframer and ffr_frame_fifo.
module fixed_frame_receiver_fifo_top (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  ffr_pkg::cfg_idx_t    cfg_index,
    input  logic [7:0]           cfg_data,
    // input items
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [7:0]           rx_byte,
    // result items
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 frame_valid,
    output logic                 enable_frame,
    output logic [7:0]           second_byte,
    output logic [7:0]           msg_id,
    output logic [7:0]           data_first,
    output logic [7:0]           data_second,
    output logic [7:0]           check_byte,
    output logic                 bad_checksum,
    output logic                 frame_dropped,
    output logic [3:0]           queued_count
);
    import ffr_pkg::*;

    logic [7:0] header_reg, enable_id_reg;

    logic       s1_valid_reg;
    logic       s1_action_reg;
    logic [7:0] s1_byte_reg;
    logic       advance;

    logic       out_valid_reg;
    logic       frame_valid_reg, enable_frame_reg;
    logic       bad_checksum_reg, frame_dropped_reg;
    frame_t     enable_bytes_reg;

    frm_evt_t   evt;
    frame_t     frame;
    fifo_ctl_t  fifo_ctl;
    frame_t     fifo_rd_data;
    cnt_t       fifo_count;
    logic       fifo_full, fifo_empty;
    logic       take_byte;
    logic       good_enable, bad_sum, drop;
    frame_t     shown;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= HEADER_RESET;
            enable_id_reg <= ENABLE_ID_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEADER:    header_reg    <= cfg_data;
                REG_ENABLE_ID: enable_id_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Input register; the item is worked on as it moves on to the result register
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action;
            s1_byte_reg   <= rx_byte;
        end
    end

    // Frame assembly
    assign take_byte = advance && (s1_action_reg == ACT_BYTE);

    ffr_deframer u_deframer (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take_byte),
        .rx_byte       (s1_byte_reg),
        .header_value  (header_reg),
        .enable_msg_id (enable_id_reg),
        .evt           (evt),
        .frame         (frame)
    );

    // Frame disposition
    assign good_enable  = evt.done && evt.sum_ok && evt.is_enable;
    assign bad_sum      = evt.done && !evt.sum_ok;
    assign drop         = evt.done && evt.sum_ok && !evt.is_enable && fifo_full;
    assign fifo_ctl.push = evt.done && evt.sum_ok && !evt.is_enable && !fifo_full;
    assign fifo_ctl.pop  = advance && (s1_action_reg == ACT_POP) && !fifo_empty;

    ffr_frame_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fifo_ctl),
        .wr_data (frame),
        .rd_data (fifo_rd_data),
        .count   (fifo_count),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            frame_valid_reg   <= 1'b0;
            enable_frame_reg  <= 1'b0;
            bad_checksum_reg  <= 1'b0;
            frame_dropped_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg     <= 1'b1;
            frame_valid_reg   <= fifo_ctl.pop;
            enable_frame_reg  <= good_enable;
            bad_checksum_reg  <= bad_sum;
            frame_dropped_reg <= drop;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (good_enable)
            enable_bytes_reg <= frame;
    end

    // Byte fields are zero unless a frame is being shown. FIFO read data and count
    // change only on an advance, so they stay matched to the held result.
    always_comb
    begin
        if (frame_valid_reg)
            shown = fifo_rd_data;
        else if (enable_frame_reg)
            shown = enable_bytes_reg;
        else
            shown = '0;
    end

    assign out_valid     = out_valid_reg;
    assign frame_valid   = frame_valid_reg;
    assign enable_frame  = enable_frame_reg;
    assign bad_checksum  = bad_checksum_reg;
    assign frame_dropped = frame_dropped_reg;
    assign second_byte   = shown.second_byte;
    assign msg_id        = shown.msg_id;
    assign data_first    = shown.data_first;
    assign data_second   = shown.data_second;
    assign check_byte    = shown.check_byte;
    assign queued_count  = sat_count(fifo_count);

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for fixed_frame_receiver_fifo_top: drives bytes and pops with random gaps and
// stalls, predicts each result from its own model of the deframer and FIFO, checks each field.
// Depends on ffr_pkg and the RTL in hdl/.
module testbench;
    import ffr_pkg::*;

    // Writes to this index land beyond the register list and must be ignored
    localparam cfg_idx_t REG_BEYOND_LIST = '1;

    // One expected transfer on the result channel
    typedef struct packed {
        logic       frame_valid;
        logic       enable_frame;
        frame_t     bytes;
        logic       bad_checksum;
        logic       frame_dropped;
        logic [3:0] queued_count;
    } rx_result_t;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    cfg_idx_t   cfg_index   = REG_HEADER;
    logic [7:0] cfg_data    = 8'h00;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic       action      = ACT_BYTE;
    logic [7:0] rx_byte     = 8'h00;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic       frame_valid;
    logic       enable_frame;
    logic [7:0] second_byte;
    logic [7:0] msg_id;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [7:0] check_byte;
    logic       bad_checksum;
    logic       frame_dropped;
    logic [3:0] queued_count;

    // Predictor state: registers, deframer and frame queue
    logic [7:0] hdr_byte;
    logic [7:0] enable_id;
    logic       collecting;
    int         tail_pos;
    logic [7:0] tail_bytes [1:FRAME_TAIL];
    frame_t     queue_mem [FIFO_DEPTH];
    int         q_wr;
    int         q_rd;
    int         q_fill;

    rx_result_t pending_results [$];
    int         error_count = 0;
    bit         no_idle     = 1'b0;

    fixed_frame_receiver_fifo_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_valid   (frame_valid),
        .enable_frame  (enable_frame),
        .second_byte   (second_byte),
        .msg_id        (msg_id),
        .data_first    (data_first),
        .data_second   (data_second),
        .check_byte    (check_byte),
        .bad_checksum  (bad_checksum),
        .frame_dropped (frame_dropped),
        .queued_count  (queued_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Wait before each transfer, none during a no-idle stretch
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // Random byte biased towards the extremes and the header value
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = hdr_byte;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Advance the frame model by one byte or pop and give the result it causes
    task automatic deframe_step(input logic act, input logic [7:0] b, output rx_result_t r);
        logic [7:0] sum8;
        frame_t     f;
        r = '0;
        if (act == ACT_BYTE)
        begin
            if (!collecting)
            begin
                if (b == hdr_byte)
                begin
                    collecting = 1'b1;
                    tail_pos   = 1;
                end
            end
            else
            begin
                tail_bytes[tail_pos] = b;
                tail_pos++;
                if (tail_pos > FRAME_TAIL)
                begin
                    f = '{check_byte: tail_bytes[5], data_second: tail_bytes[4],
                          data_first: tail_bytes[3], msg_id: tail_bytes[2],
                          second_byte: tail_bytes[1]};
                    sum8 = tail_bytes[2] + tail_bytes[3] + tail_bytes[4] + tail_bytes[5];
                    if (sum8 != 8'h00)
                        r.bad_checksum = 1'b1;
                    else if (f.msg_id == enable_id)
                    begin
                        r.enable_frame = 1'b1;
                        r.bytes        = f;
                    end
                    else if (q_fill < FIFO_DEPTH)
                    begin
                        queue_mem[q_wr] = f;
                        q_wr = (q_wr + 1) % FIFO_DEPTH;
                        q_fill++;
                    end
                    else
                        r.frame_dropped = 1'b1;
                    collecting = 1'b0;
                    tail_pos   = 0;
                end
            end
        end
        else if (q_fill != 0)
        begin
            r.frame_valid = 1'b1;
            r.bytes       = queue_mem[q_rd];
            q_rd = (q_rd + 1) % FIFO_DEPTH;
            q_fill--;
        end
        r.queued_count = (q_fill > 15) ? 4'd15 : 4'(q_fill);
    endtask

    // One input transfer, with its prediction queued on acceptance
    task automatic send_item(input logic act, input logic [7:0] b);
        int         gap;
        rx_result_t r;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        deframe_step(act, b, r);
        pending_results.push_back(r);
    endtask

    task automatic send_pop();
        send_item(ACT_POP, 8'($urandom_range(0, 255)));
    endtask

    // Header plus five bytes; the check byte makes bytes two to five sum to zero when good
    task automatic send_frame(input logic [7:0] second, input logic [7:0] msg,
                              input logic [7:0] d1, input logic [7:0] d2, input bit good);
        logic [7:0] chk;
        chk = 8'h00 - msg - d1 - d2;
        if (!good)
            chk = chk + 8'($urandom_range(1, 255));
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, second);
        send_item(ACT_BYTE, msg);
        send_item(ACT_BYTE, d1);
        send_item(ACT_BYTE, d2);
        send_item(ACT_BYTE, chk);
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, only while nothing is in flight
    task automatic cfg_write(input cfg_idx_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_HEADER)
            hdr_byte = value;
        else if (idx == REG_ENABLE_ID)
            enable_id = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mix of well-formed frames, pops, stray bytes and cut-short frames
    task automatic run_traffic(input int n_items);
        int         sent;
        int         k;
        logic [7:0] msg;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            k = $urandom_range(0, 19);
            if (k <= 8)
            begin
                msg = ($urandom_range(0, 3) == 0) ? enable_id : pick_byte();
                send_frame(pick_byte(), msg, pick_byte(), pick_byte(),
                           $urandom_range(0, 4) != 0);
                sent += 6;
            end
            else if (k <= 15)
            begin
                send_pop();
                sent++;
            end
            else if (k <= 17)
            begin
                // stray byte while hunting
                b = 8'($urandom_range(0, 255));
                if (b == hdr_byte)
                    b = ~b;
                send_item(ACT_BYTE, b);
                sent++;
            end
            else
            begin
                // frame cut short; following traffic completes it
                send_item(ACT_BYTE, hdr_byte);
                repeat ($urandom_range(1, 4))
                begin
                    send_item(ACT_BYTE, pick_byte());
                    sent++;
                end
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_directed();
        send_pop();
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'hFF);
        // enable frame shown at once, not queued
        send_frame(8'h00, enable_id, 8'hFF, 8'h00, 1'b1);
        // header value taken as data inside a frame
        send_frame(8'hFF, hdr_byte, hdr_byte, 8'h00, 1'b1);
        // bad checksum, with a pop in the middle of assembly
        send_item(ACT_BYTE, hdr_byte);
        send_item(ACT_BYTE, 8'h12);
        send_pop();
        send_item(ACT_BYTE, 8'h34);
        send_item(ACT_BYTE, 8'h56);
        send_item(ACT_BYTE, 8'h78);
        send_item(ACT_BYTE, 8'h01);
        send_pop();
    endtask

    task automatic test_fifo_overflow();
        int n;
        n = q_fill;
        no_idle = 1'b1;
        repeat (n) send_pop();
        no_idle = 1'b0;
        repeat (FIFO_DEPTH + 2)
            send_frame(pick_byte(), enable_id ^ 8'h01, pick_byte(), pick_byte(), 1'b1);
        repeat (FIFO_DEPTH + 1) send_pop();
    endtask

    task automatic test_register_settings();
        logic [7:0] hdr_set [3];
        logic [7:0] id_set [3];
        hdr_set = '{8'h00, 8'hFF, 8'($urandom_range(0, 255))};
        id_set  = '{8'h00, 8'hFF, 8'($urandom_range(0, 255))};
        foreach (hdr_set[i])
        begin
            wait_drain();
            cfg_write(REG_HEADER, hdr_set[i]);
            cfg_write(REG_ENABLE_ID, id_set[i]);
            cfg_write(REG_BEYOND_LIST, 8'($urandom_range(0, 255)));
            run_traffic(150);
        end
    endtask

    task automatic test_random_traffic();
        wait_drain();
        cfg_write(REG_HEADER, HEADER_RESET);
        cfg_write(REG_ENABLE_ID, ENABLE_ID_RESET);
        run_traffic(250);
        wait_drain();
        run_traffic(250);
    endtask

    // Receiver side: random stall before each result transfer
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            k = draw_wait();
            repeat (k)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        rx_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("frame_valid", 8'(e.frame_valid), 8'(frame_valid));
                check_field("enable_frame", 8'(e.enable_frame), 8'(enable_frame));
                check_field("second_byte", e.bytes.second_byte, second_byte);
                check_field("msg_id", e.bytes.msg_id, msg_id);
                check_field("data_first", e.bytes.data_first, data_first);
                check_field("data_second", e.bytes.data_second, data_second);
                check_field("check_byte", e.bytes.check_byte, check_byte);
                check_field("bad_checksum", 8'(e.bad_checksum), 8'(bad_checksum));
                check_field("frame_dropped", 8'(e.frame_dropped), 8'(frame_dropped));
                check_field("queued_count", 8'(e.queued_count), 8'(queued_count));
            end
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        hdr_byte   = HEADER_RESET;
        enable_id  = ENABLE_ID_RESET;
        collecting = 1'b0;
        tail_pos   = 0;
        q_wr       = 0;
        q_rd       = 0;
        q_fill     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_fifo_overflow();
        test_register_settings();
        test_random_traffic();

        wait_drain();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
